### sv/gsf_pkg.sv
// Shared constants, FSM state type and control structs for the GF(2) reducer.
package gsf_pkg;

  localparam int DefRows   = 4;
  localparam int DefCols   = 8;
  localparam int RowWidth  = 8;
  localparam int RowNumWidth = 2;

  typedef enum logic [1:0] {
    StLoad,
    StElim,
    StOut
  } state_t;

  typedef struct packed {
    logic load;
    logic elim;
    logic shift_out;
  } cmd_t;

  typedef struct packed {
    logic load_complete;
    logic elim_last;
    logic out_last;
  } status_t;

endpackage

### sv/gsf_row_if.sv
// Input channel carrying one matrix row per transaction.
interface gsf_row_if;
  import gsf_pkg::*;

  logic                valid;
  logic                ready;
  logic [RowWidth-1:0] row_word;
  logic                last_row;

  modport source (output valid, output row_word, output last_row, input ready);
  modport sink (input valid, input row_word, input last_row, output ready);
endinterface

### sv/gsf_out_if.sv
// Output channel carrying one reduced row per transaction.
interface gsf_out_if;
  import gsf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [RowWidth-1:0]    reduced_row;
  logic [RowNumWidth-1:0] row_number;
  logic                   rank_deficient;
  logic                   last_out;

  modport source (
    output valid, output reduced_row, output row_number,
    output rank_deficient, output last_out, input ready
  );
  modport sink (
    input valid, input reduced_row, input row_number,
    input rank_deficient, input last_out, output ready
  );
endinterface

### sv/gsf_datapath.sv
// Row register lanes, pivot search and elimination, and the load/pivot/output counters.
module gsf_datapath #(
  parameter int ROWS = gsf_pkg::DefRows,
  parameter int COLS = gsf_pkg::DefCols
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gsf_pkg::cmd_t                    cmd,
  output gsf_pkg::status_t                 status,
  input  logic [gsf_pkg::RowWidth-1:0]     row_word,
  input  logic                             last_row,
  output logic [gsf_pkg::RowWidth-1:0]     reduced_row,
  output logic [gsf_pkg::RowNumWidth-1:0]  row_number,
  output logic                             rank_deficient,
  output logic                             last_out
);
  import gsf_pkg::*;

  localparam int CW = $clog2(ROWS + 1);
  localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RowWidth-1:0] ColMask =
    (COLS >= RowWidth) ? {RowWidth{1'b1}} : RowWidth'((64'd1 << COLS) - 64'd1);
  localparam logic [CW-1:0] LastIdx = CW'(ROWS - 1);

  logic [RowWidth-1:0] rows [ROWS];
  logic [CW-1:0]       load_count;
  logic [CW-1:0]       pivot;
  logic [CW-1:0]       out_count;
  logic                missing;

  logic                has_col;
  logic [2:0]          col;
  logic [ROWS-1:0]     hit;
  logic [ROWS-1:0]     first;
  logic                found;
  logic [RowWidth-1:0] piv_row;
  logic [RowWidth-1:0] cur_row;
  logic [RowWidth-1:0] word_masked;

  assign word_masked = row_word & ColMask;

  // Pivot column exists only below COLS and within the stored row width
  assign has_col = (32'(pivot) < COLS) && (32'(pivot) < RowWidth);
  assign col     = 3'(pivot);

  // Flag rows at or below the pivot index with a one in the pivot column
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      hit[r] = has_col && (32'(r) >= 32'(pivot)) && rows[r][col];
    end
  end

  // Keep only the first candidate row
  assign first = hit & (~hit + ROWS'(1));
  assign found = |hit;

  // Select the pivot row and the row currently in the pivot slot
  always_comb begin
    piv_row = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (first[r]) begin
        piv_row = piv_row | rows[r];
      end
    end
  end
  assign cur_row = rows[pivot[IW-1:0]];

  // Row lanes: load, swap and eliminate, shift out
  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      logic [RowWidth-1:0] base;
      base = rows[r];
      if (cmd.load) begin
        if (CW'(r) == load_count) begin
          rows[r] <= word_masked;
        end else if (CW'(r) > load_count && status.load_complete) begin
          rows[r] <= '0;
        end
      end else if (cmd.elim) begin
        if (found) begin
          if (CW'(r) == pivot) begin
            base = piv_row;
          end else if (first[r]) begin
            base = cur_row;
          end
          if (CW'(r) != pivot && base[col]) begin
            base = base ^ piv_row;
          end
          rows[r] <= base;
        end
      end else if (cmd.shift_out) begin
        if (r < ROWS - 1) begin
          rows[r] <= rows[(r + 1) % ROWS];
        end
      end
    end
  end

  // Advance counters and track the missing-pivot flag
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      pivot      <= '0;
      out_count  <= '0;
      missing    <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (status.load_complete) begin
          load_count <= '0;
          pivot      <= '0;
          missing    <= 1'b0;
        end else begin
          load_count <= load_count + CW'(1);
        end
      end
      if (cmd.elim) begin
        if (!found) begin
          missing <= 1'b1;
        end
        pivot <= status.elim_last ? '0 : pivot + CW'(1);
      end
      if (cmd.shift_out) begin
        out_count <= status.out_last ? '0 : out_count + CW'(1);
      end
    end
  end

  assign status.load_complete = last_row || (load_count == LastIdx);
  assign status.elim_last     = (pivot == LastIdx);
  assign status.out_last      = (out_count == LastIdx);

  assign reduced_row    = rows[0];
  assign row_number     = RowNumWidth'(out_count);
  assign rank_deficient = missing;
  assign last_out       = (out_count == LastIdx);

endmodule

### sv/gsf_ctrl.sv
// Controller state machine sequencing load, elimination and output of one matrix.
module gsf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output gsf_pkg::cmd_t    cmd,
  input  gsf_pkg::status_t status
);
  import gsf_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StLoad;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      StLoad: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.load_complete) begin
            state_next = StElim;
          end
        end
      end
      StElim: begin
        cmd.elim = 1'b1;
        if (status.elim_last) begin
          state_next = StOut;
        end
      end
      StOut: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift_out = 1'b1;
          if (status.out_last) begin
            state_next = StLoad;
          end
        end
      end
      default: begin
        state_next = StLoad;
      end
    endcase
  end

endmodule

### sv/gf2_systematic_form.sv
// Top level of the GF(2) systematic-form reducer: controller plus row datapath.
// Operation: rows are loaded until last_row or ROWS rows, then ROWS elimination steps
// (one pivot per cycle), then ROWS output transactions.
// A new matrix is accepted only after the last row of the previous one is shifted out;
// output shifts one row per cycle while row_out.ready is high.
// Reset (synchronous, rst high) returns to loading with counters and flag cleared.
module gf2_systematic_form #(
  parameter int ROWS = gsf_pkg::DefRows,
  parameter int COLS = gsf_pkg::DefCols
) (
  input logic        clk,
  input logic        rst,
  gsf_row_if.sink    row_in,
  gsf_out_if.source  row_out
);
  import gsf_pkg::*;

  cmd_t    cmd;
  status_t status;

  gsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (row_in.valid),
    .in_ready  (row_in.ready),
    .out_valid (row_out.valid),
    .out_ready (row_out.ready),
    .cmd       (cmd),
    .status    (status)
  );

  gsf_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .row_word       (row_in.row_word),
    .last_row       (row_in.last_row),
    .reduced_row    (row_out.reduced_row),
    .row_number     (row_out.row_number),
    .rank_deficient (row_out.rank_deficient),
    .last_out       (row_out.last_out)
  );

endmodule
